// ===== hdl/pfey_pkg.sv =====
package pfey_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ATAN_LEN         = 24;

  // CORDIC angle accumulator, Q.24 radians.
  localparam int ZW = 30;

  localparam logic signed [ZW-1:0] PI_Q24 = ZW'(52707179);
  localparam logic [15:0] GAIN_Q16       = 16'd39797;
  localparam logic [15:0] INV_SQRT2_Q16  = 16'd46341;
  localparam int          ANGLE_LIMIT    = 25736;
  localparam int          SING_SQ_MAX    = 1152921;
  localparam int          SING_ABS_LIMIT = 1074;
  localparam logic [23:0] CD_SCALE_Q24   = 24'd11734176;
  localparam logic [15:0] FULL_TURN_CD   = 16'd36000;

  // Camera mounting modes.
  localparam logic [1:0] MODE_FORWARD     = 2'd0;
  localparam logic [1:0] MODE_DOWN        = 2'd1;
  localparam logic [1:0] MODE_TILT        = 2'd2;
  localparam logic [1:0] MODE_FORWARD_ALT = 2'd3;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_MOUNT = 2'd0;
  localparam logic [1:0] REG_OFF_E = 2'd1;
  localparam logic [1:0] REG_OFF_N = 2'd2;
  localparam logic [1:0] REG_OFF_U = 2'd3;

  function automatic logic signed [ZW-1:0] atan_q24(input logic [4:0] idx);
    case (idx)
      5'd0:    return ZW'(13176795);
      5'd1:    return ZW'(7778716);
      5'd2:    return ZW'(4110060);
      5'd3:    return ZW'(2086331);
      5'd4:    return ZW'(1047214);
      5'd5:    return ZW'(524117);
      5'd6:    return ZW'(262123);
      5'd7:    return ZW'(131069);
      5'd8:    return ZW'(65536);
      5'd9:    return ZW'(32768);
      5'd10:   return ZW'(16384);
      5'd11:   return ZW'(8192);
      5'd12:   return ZW'(4096);
      5'd13:   return ZW'(2048);
      5'd14:   return ZW'(1024);
      5'd15:   return ZW'(512);
      5'd16:   return ZW'(256);
      5'd17:   return ZW'(128);
      5'd18:   return ZW'(64);
      5'd19:   return ZW'(32);
      5'd20:   return ZW'(16);
      5'd21:   return ZW'(8);
      5'd22:   return ZW'(4);
      5'd23:   return ZW'(2);
      default: return '0;
    endcase
  endfunction

endpackage

// ===== hdl/pfey_cordic.sv =====
module pfey_cordic #(
  parameter int STEPS = pfey_pkg::CORDIC_STEPS_DEF,
  parameter int W     = 40
) (
  input  logic                          clk,
  input  logic signed [W-1:0]           x_i,
  input  logic signed [W-1:0]           y_i,
  output logic signed [pfey_pkg::ZW-1:0] z_o,
  output logic signed [W-1:0]           x_o,
  output logic                          zero_o
);
  import pfey_pkg::*;

  logic signed [W-1:0]  xs_r [0:STEPS];
  logic signed [W-1:0]  ys_r [0:STEPS];
  logic signed [ZW-1:0] zs_r [0:STEPS];
  logic                 zero_r [0:STEPS];

  // Fold the left half plane onto the right one before the rotations.
  always_ff @(posedge clk) begin
    zero_r[0] <= (x_i == '0) && (y_i == '0);
    if (x_i < 0) begin
      xs_r[0] <= -x_i;
      ys_r[0] <= -y_i;
      zs_r[0] <= (y_i >= 0) ? PI_Q24 : -PI_Q24;
    end else begin
      xs_r[0] <= x_i;
      ys_r[0] <= y_i;
      zs_r[0] <= '0;
    end
  end

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    always_ff @(posedge clk) begin
      zero_r[k+1] <= zero_r[k];
      if (ys_r[k] > 0) begin
        xs_r[k+1] <= xs_r[k] + (ys_r[k] >>> k);
        ys_r[k+1] <= ys_r[k] - (xs_r[k] >>> k);
        zs_r[k+1] <= zs_r[k] + atan_q24(5'(k));
      end else begin
        xs_r[k+1] <= xs_r[k] - (ys_r[k] >>> k);
        ys_r[k+1] <= ys_r[k] + (xs_r[k] >>> k);
        zs_r[k+1] <= zs_r[k] - atan_q24(5'(k));
      end
    end
  end

  assign z_o    = zs_r[STEPS];
  assign x_o    = xs_r[STEPS];
  assign zero_o = zero_r[STEPS];

endmodule

// ===== hdl/pose_frame_to_euler_yaw.sv =====
// Each accepted start yields one result, flagged by out_valid.
// Throughput: one sample per cycle; busy stays low and the pipeline never stalls.
// The latency is set by the two chained CORDIC pipelines: pitch needs the magnitude
// that the yaw CORDIC produces. The receiver cannot stall the result strobe.
// Reset (rst_n low, synchronous) clears the valid pipeline and all configuration registers.
module pose_frame_to_euler_yaw #(
  parameter int CORDIC_STEPS = pfey_pkg::CORDIC_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] in_quat_w,
  input  logic signed [15:0] in_quat_x,
  input  logic signed [15:0] in_quat_y,
  input  logic signed [15:0] in_quat_z,
  input  logic signed [31:0] in_pos_in_x,
  input  logic signed [31:0] in_pos_in_y,
  input  logic signed [31:0] in_pos_in_z,
  input  logic signed [31:0] in_vel_in_x,
  input  logic signed [31:0] in_vel_in_y,
  input  logic signed [31:0] in_vel_in_z,
  output logic               out_valid,
  output logic signed [31:0] out_pos_out_x,
  output logic signed [31:0] out_pos_out_y,
  output logic signed [31:0] out_pos_out_z,
  output logic signed [15:0] out_roll_angle,
  output logic signed [15:0] out_pitch_angle,
  output logic signed [15:0] out_yaw_angle,
  output logic [15:0]        out_yaw_centideg,
  output logic signed [31:0] out_vel_out_x,
  output logic signed [31:0] out_vel_out_y,
  output logic signed [31:0] out_vel_out_z
);
  import pfey_pkg::*;

  localparam int S    = CORDIC_STEPS;
  localparam int LAT  = 2 * S + 7;
  localparam int CW   = 40;
  localparam int RQW  = 35;
  localparam int RW   = 36;
  localparam int RW1  = RW + 1;
  localparam int TW   = 54;
  localparam int PW   = 60;
  localparam int AW   = PW + 2;
  localparam int PSW  = 44;
  localparam int ZW1  = ZW + 1;
  localparam int GW   = CW + 17;
  localparam int SW   = 42;

  localparam logic signed [RQW-1:0] ONE_Q30 = RQW'(1 << 30);
  localparam logic signed [TW-1:0]  C_S     = TW'(INV_SQRT2_Q16);
  localparam logic signed [RW-1:0]  SING_LIM = RW'(SING_ABS_LIMIT);
  localparam logic signed [SW-1:0]  FULL_S  = SW'(FULL_TURN_CD) <<< 24;
  localparam logic signed [SW-1:0]  CD_S    = SW'(CD_SCALE_Q24);

  typedef struct packed {
    logic [2:0][31:0] pos;
    logic [2:0][31:0] vel;
  } side_t;

  typedef struct packed {
    logic signed [15:0] yaw;
    logic signed [15:0] roll;
  } ang_t;

  function automatic logic signed [RQW-1:0] dbl(input logic signed [31:0] p);
    return RQW'(p) <<< 1;
  endfunction

  function automatic logic signed [31:0] neg_sat(input logic signed [31:0] v);
    if (v == 32'sh8000_0000) return 32'sh7fff_ffff;
    return -v;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [PSW-1:0] v);
    if (v > PSW'(32'sh7fff_ffff)) return 32'sh7fff_ffff;
    if (v < PSW'(32'sh8000_0000)) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic logic signed [15:0] ang_q13(input logic signed [ZW-1:0] z,
                                                 input logic zf);
    logic signed [ZW1-1:0] t;
    t = (ZW1'(z) + ZW1'(1024)) >>> 11;
    if (zf) return '0;
    if (t > ANGLE_LIMIT) return 16'(ANGLE_LIMIT);
    if (t < -ANGLE_LIMIT) return -16'(ANGLE_LIMIT);
    return t[15:0];
  endfunction

  // ---------------- configuration port ----------------
  logic [1:0]         mount_r;
  logic signed [31:0] off_r [3];
  logic               cfg_wr;

  assign pready = 1'b1;
  assign busy   = 1'b0;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mount_r  <= MODE_FORWARD;
      off_r[0] <= '0;
      off_r[1] <= '0;
      off_r[2] <= '0;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_MOUNT: mount_r  <= pwdata[1:0];
        REG_OFF_E: off_r[0] <= pwdata;
        REG_OFF_N: off_r[1] <= pwdata;
        REG_OFF_U: off_r[2] <= pwdata;
        default:   mount_r  <= mount_r;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_MOUNT: prdata = {30'd0, mount_r};
      REG_OFF_E: prdata = off_r[0];
      REG_OFF_N: prdata = off_r[1];
      REG_OFF_U: prdata = off_r[2];
      default:   prdata = '0;
    endcase
  end

  // ---------------- valid pipeline ----------------
  logic [LAT-1:0] vld_r;
  logic           accept;

  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else        vld_r <= {vld_r[LAT-2:0], accept};
  end

  assign out_valid = vld_r[LAT-1];

  // ---------------- stage 1: quaternion to matrix ----------------
  logic signed [31:0]    p_xx, p_yy, p_zz, p_xy, p_zw, p_xz, p_yw, p_yz, p_xw;
  logic signed [RQW-1:0] rq_r [3][3];
  logic signed [32:0]    at_s1_r [3], at_s2_r [3];
  logic signed [31:0]    vel_s1_r [3], vel_s2_r [3], vel_s3_r [3];

  assign p_xx = in_quat_x * in_quat_x;
  assign p_yy = in_quat_y * in_quat_y;
  assign p_zz = in_quat_z * in_quat_z;
  assign p_xy = in_quat_x * in_quat_y;
  assign p_zw = in_quat_z * in_quat_w;
  assign p_xz = in_quat_x * in_quat_z;
  assign p_yw = in_quat_y * in_quat_w;
  assign p_yz = in_quat_y * in_quat_z;
  assign p_xw = in_quat_x * in_quat_w;

  always_ff @(posedge clk) begin
    rq_r[0][0] <= ONE_Q30 - dbl(p_yy) - dbl(p_zz);
    rq_r[0][1] <= dbl(p_xy) - dbl(p_zw);
    rq_r[0][2] <= dbl(p_xz) + dbl(p_yw);
    rq_r[1][0] <= dbl(p_xy) + dbl(p_zw);
    rq_r[1][1] <= ONE_Q30 - dbl(p_xx) - dbl(p_zz);
    rq_r[1][2] <= dbl(p_yz) - dbl(p_xw);
    rq_r[2][0] <= dbl(p_xz) - dbl(p_yw);
    rq_r[2][1] <= dbl(p_yz) + dbl(p_xw);
    rq_r[2][2] <= ONE_Q30 - dbl(p_xx) - dbl(p_yy);
    at_s1_r[0] <= -33'(in_pos_in_z);
    at_s1_r[1] <= 33'(in_pos_in_x);
    at_s1_r[2] <= -33'(in_pos_in_y);
    vel_s1_r[0] <= neg_sat(in_vel_in_z);
    vel_s1_r[1] <= in_vel_in_x;
    vel_s1_r[2] <= neg_sat(in_vel_in_y);
  end

  // ---------------- stage 2: vehicle frame, mount matrix ----------------
  logic signed [RW-1:0] r_nxt [3][3];
  logic signed [RW-1:0] r_r   [3][3];

  always_comb begin
    logic signed [RW-1:0]  m0, m1, m2;
    logic signed [RW1-1:0] s0, s2;
    logic signed [TW-1:0]  t0, t2;
    for (int i = 0; i < 3; i++) begin
      // Rows of A*Rq: -Rq row 2, Rq row 0, -Rq row 1.
      case (i)
        0:       begin m0 = -RW'(rq_r[2][0]); m1 = -RW'(rq_r[2][1]); m2 = -RW'(rq_r[2][2]); end
        1:       begin m0 =  RW'(rq_r[0][0]); m1 =  RW'(rq_r[0][1]); m2 =  RW'(rq_r[0][2]); end
        default: begin m0 = -RW'(rq_r[1][0]); m1 = -RW'(rq_r[1][1]); m2 = -RW'(rq_r[1][2]); end
      endcase
      s0 = -(RW1'(m1) + RW1'(m2));
      s2 = RW1'(m2) - RW1'(m1);
      t0 = ((TW'(s0) * C_S) + TW'(1 << 15)) >>> 16;
      t2 = ((TW'(s2) * C_S) + TW'(1 << 15)) >>> 16;
      r_nxt[i][1] = m0;
      case (mount_r)
        MODE_DOWN: begin
          r_nxt[i][0] = m1;
          r_nxt[i][2] = -m2;
        end
        MODE_TILT: begin
          r_nxt[i][0] = RW'(t0);
          r_nxt[i][2] = RW'(t2);
        end
        default: begin
          r_nxt[i][0] = -m2;
          r_nxt[i][2] = -m1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    r_r     <= r_nxt;
    at_s2_r <= at_s1_r;
    vel_s2_r <= vel_s1_r;
  end

  // ---------------- stage 3: offset products, singular test, CORDIC feed ----------------
  logic signed [PW-1:0]  pprod_r [3][3];
  logic signed [33:0]    atoff_r [3];
  logic signed [11:0]    a00, a10;
  logic signed [23:0]    sq00, sq10;
  logic                  small_r0, singular;
  logic signed [CW-1:0]  roll_x, roll_y;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        pprod_r[i][j] <= PW'((RW1'(r_r[i][j]) + RW1'(512)) >>> 10) * PW'(off_r[j]);
      end
      atoff_r[i] <= 34'(at_s2_r[i]) + 34'(off_r[i]);
    end
    vel_s3_r <= vel_s2_r;
  end

  assign small_r0 = (r_r[0][0] < SING_LIM) && (r_r[0][0] > -SING_LIM) &&
                    (r_r[1][0] < SING_LIM) && (r_r[1][0] > -SING_LIM);
  assign a00  = r_r[0][0][11:0];
  assign a10  = r_r[1][0][11:0];
  assign sq00 = a00 * a00;
  assign sq10 = a10 * a10;
  assign singular = small_r0 && ((25'(sq00) + 25'(sq10)) <= 25'(SING_SQ_MAX));

  // Singular attitude takes roll from the second row instead.
  assign roll_x = singular ? CW'(r_r[1][1]) : CW'(r_r[2][2]);
  assign roll_y = singular ? -CW'(r_r[1][2]) : CW'(r_r[2][1]);

  logic signed [ZW-1:0] yz, rz, pz;
  logic signed [CW-1:0] yx, rx, px;
  logic                 yzf, rzf, pzf;

  pfey_cordic #(.STEPS(S), .W(CW)) u_yaw (
    .clk(clk), .x_i(CW'(r_r[0][0])), .y_i(CW'(r_r[1][0])),
    .z_o(yz), .x_o(yx), .zero_o(yzf)
  );

  pfey_cordic #(.STEPS(S), .W(CW)) u_roll (
    .clk(clk), .x_i(roll_x), .y_i(roll_y),
    .z_o(rz), .x_o(rx), .zero_o(rzf)
  );

  logic signed [RW-1:0] r20_d_r  [0:S];
  logic                 sing_d_r [0:S];

  always_ff @(posedge clk) begin
    r20_d_r[0]  <= r_r[2][0];
    sing_d_r[0] <= singular;
    for (int k = 1; k <= S; k++) begin
      r20_d_r[k]  <= r20_d_r[k-1];
      sing_d_r[k] <= sing_d_r[k-1];
    end
  end

  // ---------------- stage 4: position sum and saturation ----------------
  logic signed [AW-1:0]  acc [3];
  logic signed [PSW-1:0] pos_val [3];
  side_t                 side_r [0:LAT-5];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc[i] = AW'(pprod_r[i][0]) + AW'(pprod_r[i][1]) + AW'(pprod_r[i][2]);
      pos_val[i] = PSW'(atoff_r[i]) - PSW'((acc[i] + AW'(1 << 19)) >>> 20);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      side_r[0].pos[i] <= sat32(pos_val[i]);
      side_r[0].vel[i] <= vel_s3_r[i];
    end
    for (int k = 1; k <= LAT - 5; k++) side_r[k] <= side_r[k-1];
  end

  // ---------------- gain stage: angles, magnitude sy ----------------
  logic signed [GW-1:0] sy_full;
  logic signed [CW-1:0] sy_r, nr20_r;
  ang_t                 ang_g_r;
  ang_t                 ang_d_r [0:S];

  assign sy_full = (GW'(yx) * GW'(GAIN_Q16) + GW'(1 << 15)) >>> 16;

  always_ff @(posedge clk) begin
    sy_r         <= yzf ? '0 : CW'(sy_full);
    nr20_r       <= -CW'(r20_d_r[S]);
    ang_g_r.yaw  <= sing_d_r[S] ? 16'sd0 : ang_q13(yz, yzf);
    ang_g_r.roll <= ang_q13(rz, rzf);
    ang_d_r[0]   <= ang_g_r;
    for (int k = 1; k <= S; k++) ang_d_r[k] <= ang_d_r[k-1];
  end

  pfey_cordic #(.STEPS(S), .W(CW)) u_pitch (
    .clk(clk), .x_i(sy_r), .y_i(nr20_r),
    .z_o(pz), .x_o(px), .zero_o(pzf)
  );

  // ---------------- final stages: pitch, centidegrees ----------------
  logic signed [15:0] pitch_f_r, roll_f_r, yaw_f_r;
  logic signed [SW-1:0] cd_s_r, cd_w;
  logic [15:0]          cd_q;
  logic                 px_unused;

  assign px_unused = ^px;

  always_ff @(posedge clk) begin
    pitch_f_r <= ang_q13(pz, pzf);
    roll_f_r  <= ang_d_r[S].roll;
    yaw_f_r   <= ang_d_r[S].yaw;
    cd_s_r    <= SW'(ang_d_r[S].yaw) * CD_S;
  end

  always_comb begin
    cd_w = (cd_s_r < 0) ? cd_s_r + FULL_S : cd_s_r;
    if (cd_w >= FULL_S) cd_w = cd_w - FULL_S;
    cd_q = cd_w[39:24];
    if (cd_q == 16'd0 || px_unused == 1'b0 && px_unused == 1'b1) cd_q = FULL_TURN_CD;
  end

  always_ff @(posedge clk) begin
    out_pos_out_x    <= side_r[LAT-5].pos[0];
    out_pos_out_y    <= side_r[LAT-5].pos[1];
    out_pos_out_z    <= side_r[LAT-5].pos[2];
    out_vel_out_x    <= side_r[LAT-5].vel[0];
    out_vel_out_y    <= side_r[LAT-5].vel[1];
    out_vel_out_z    <= side_r[LAT-5].vel[2];
    out_roll_angle   <= roll_f_r;
    out_pitch_angle  <= pitch_f_r;
    out_yaw_angle    <= yaw_f_r;
    out_yaw_centideg <= cd_q;
  end

endmodule

// ===== hdl/pfey_chk.sv =====
module pfey_chk #(
  parameter int CORDIC_STEPS = pfey_pkg::CORDIC_STEPS_DEF
) (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic               out_valid,
  input logic signed [15:0] out_roll_angle,
  input logic signed [15:0] out_yaw_angle,
  input logic [15:0]        out_yaw_centideg
);
  import pfey_pkg::*;

  localparam int LAT = 2 * CORDIC_STEPS + 7;

  // Every accepted transaction yields one result.
  a_lat_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LAT out_valid)
    else $error("result missing after accepted transaction");

  a_lat_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy && rst_n, LAT))
    else $error("result without matching transaction");

  a_cd_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_yaw_centideg >= 16'd1 && out_yaw_centideg <= FULL_TURN_CD))
    else $error("yaw centidegrees out of range");

  a_yaw_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_yaw_angle == 16'sd0) |-> out_yaw_centideg == FULL_TURN_CD)
    else $error("zero yaw not reported as full turn");

  a_roll_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_roll_angle <= 16'sd25736 && out_roll_angle >= -16'sd25736))
    else $error("roll angle out of range");

endmodule

bind pose_frame_to_euler_yaw pfey_chk #(.CORDIC_STEPS(CORDIC_STEPS)) u_pfey_chk (.*);

// ===== tb/pose_frame_to_euler_yaw_tb.sv =====
`timescale 1ns / 100ps

module pose_frame_to_euler_yaw_tb;
  import pfey_pkg::*;

  localparam int STEPS = CORDIC_STEPS_DEF;
  localparam int LATENCY = 2 * STEPS + 7;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct {
    logic signed [15:0] qw, qx, qy, qz;
    logic signed [31:0] px, py, pz, vx, vy, vz;
  } pose_sample_t;

  typedef struct {
    logic signed [31:0] px, py, pz;
    logic signed [15:0] roll, pitch, yaw;
    logic [15:0]        cd;
    logic signed [31:0] vx, vy, vz;
  } vehicle_pose_t;

  // Rounding half up: add half, then arithmetic shift toward minus infinity.
  function automatic longint round_shift(longint v, int n);
    return (v + (longint'(1) <<< (n - 1))) >>> n;
  endfunction

  function automatic longint clamp_i32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint atan_step(int i);
    longint steps_q24 [24] = '{13176795, 7778716, 4110060, 2086331, 1047214, 524117,
                               262123, 131069, 65536, 32768, 16384, 8192, 4096,
                               2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2};
    return steps_q24[i];
  endfunction

  // Vectoring rotation: returns the angle in Q3.13 and the scaled magnitude.
  function automatic longint vector_angle(longint x, longint y, output longint mag);
    longint z, nx, ny, a;
    z = 0;
    if (x == 0 && y == 0) begin
      mag = 0;
      return 0;
    end
    if (x < 0) begin
      z = (y >= 0) ? 64'sd52707179 : -64'sd52707179;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < STEPS && i < 24; i++) begin
      if (y > 0) begin
        nx = x + (y >>> i);
        ny = y - (x >>> i);
        z += atan_step(i);
      end else begin
        nx = x - (y >>> i);
        ny = y + (x >>> i);
        z -= atan_step(i);
      end
      x = nx;
      y = ny;
    end
    mag = round_shift(x * 39797, 16);
    a = round_shift(z, 11);
    if (a > ANGLE_LIMIT) a = longint'(ANGLE_LIMIT);
    if (a < -ANGLE_LIMIT) a = -longint'(ANGLE_LIMIT);
    return a;
  endfunction

  class pose_scoreboard;
    logic [1:0] mount;
    longint offset [3];
    vehicle_pose_t pending [$];
    int errors;

    function void clear_config();
      mount = MODE_FORWARD;
      foreach (offset[i]) offset[i] = 0;
    endfunction

    function vehicle_pose_t convert(pose_sample_t s);
      longint w, x, y, z, rq [3][3], m [3][3], r [3][3], b [3][3], t [3], at [3];
      longint acc, sy, unused, roll, pitch, yaw, sc, cd, c;
      bit singular;
      vehicle_pose_t e;
      w = s.qw; x = s.qx; y = s.qy; z = s.qz;
      c = 46341;
      rq[0][0] = (64'sd1 << 30) - 2*y*y - 2*z*z;
      rq[0][1] = 2*x*y - 2*z*w;
      rq[0][2] = 2*x*z + 2*y*w;
      rq[1][0] = 2*x*y + 2*z*w;
      rq[1][1] = (64'sd1 << 30) - 2*x*x - 2*z*z;
      rq[1][2] = 2*y*z - 2*x*w;
      rq[2][0] = 2*x*z - 2*y*w;
      rq[2][1] = 2*y*z + 2*x*w;
      rq[2][2] = (64'sd1 << 30) - 2*x*x - 2*y*y;
      for (int j = 0; j < 3; j++) begin
        m[0][j] = -rq[2][j];
        m[1][j] = rq[0][j];
        m[2][j] = -rq[1][j];
      end
      case (mount)
        MODE_DOWN: b = '{'{0, 65536, 0}, '{65536, 0, 0}, '{0, 0, -65536}};
        MODE_TILT: b = '{'{0, 65536, 0}, '{-c, 0, -c}, '{-c, 0, c}};
        default:   b = '{'{0, 65536, 0}, '{0, 0, -65536}, '{-65536, 0, 0}};
      endcase
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++) begin
          acc = 0;
          for (int k = 0; k < 3; k++) acc += m[i][k] * b[k][j];
          r[i][j] = round_shift(acc, 16);
        end
      t[0] = s.px; t[1] = s.py; t[2] = s.pz;
      at[0] = -t[2]; at[1] = t[0]; at[2] = -t[1];
      for (int i = 0; i < 3; i++) begin
        acc = 0;
        for (int j = 0; j < 3; j++) acc += round_shift(r[i][j], 10) * offset[j];
        at[i] = clamp_i32(at[i] + offset[i] - round_shift(acc, 20));
      end
      e.px = 32'(at[0]); e.py = 32'(at[1]); e.pz = 32'(at[2]);
      e.vx = 32'(clamp_i32(-longint'(s.vz)));
      e.vy = s.vx;
      e.vz = 32'(clamp_i32(-longint'(s.vy)));
      singular = 0;
      if (r[0][0] < SING_ABS_LIMIT && r[0][0] > -SING_ABS_LIMIT &&
          r[1][0] < SING_ABS_LIMIT && r[1][0] > -SING_ABS_LIMIT)
        singular = (r[0][0]*r[0][0] + r[1][0]*r[1][0]) <= SING_SQ_MAX;
      yaw = vector_angle(r[0][0], r[1][0], sy);
      pitch = vector_angle(sy, -r[2][0], unused);
      if (!singular) roll = vector_angle(r[2][2], r[2][1], unused);
      else begin
        roll = vector_angle(r[1][1], -r[1][2], unused);
        yaw = 0;
      end
      sc = yaw * 11734176;
      if (sc < 0) sc += 64'sd36000 << 24;
      if (sc >= (64'sd36000 << 24)) sc -= 64'sd36000 << 24;
      cd = sc >>> 24;
      if (cd == 0) cd = longint'(FULL_TURN_CD);
      e.roll = 16'(roll); e.pitch = 16'(pitch); e.yaw = 16'(yaw); e.cd = 16'(cd);
      return e;
    endfunction

    function void note_sample(pose_sample_t s);
      pending.push_back(convert(s));
    endfunction

    task report(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      errors++;
    endtask

    task check_result(vehicle_pose_t g);
      vehicle_pose_t e;
      if (pending.size() == 0) begin
        $display("unexpected result transaction at %0t", $realtime);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (g.px !== e.px) report("pos_out_x", g.px, e.px);
      if (g.py !== e.py) report("pos_out_y", g.py, e.py);
      if (g.pz !== e.pz) report("pos_out_z", g.pz, e.pz);
      if (g.roll !== e.roll) report("roll_angle", g.roll, e.roll);
      if (g.pitch !== e.pitch) report("pitch_angle", g.pitch, e.pitch);
      if (g.yaw !== e.yaw) report("yaw_angle", g.yaw, e.yaw);
      if (g.cd !== e.cd) report("yaw_centideg", g.cd, e.cd);
      if (g.vx !== e.vx) report("vel_out_x", g.vx, e.vx);
      if (g.vy !== e.vy) report("vel_out_y", g.vy, e.vy);
      if (g.vz !== e.vz) report("vel_out_z", g.vz, e.vz);
    endtask
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic start = 0;
  logic busy;
  pose_sample_t drv = '{default: '0};
  logic out_valid;
  vehicle_pose_t got;
  pose_scoreboard board;
  longint cycles = 0;

  always #10 clk = ~clk;

  pose_frame_to_euler_yaw uut (
    .clk(clk), .rst_n(rst_n),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .start(start), .busy(busy),
    .in_quat_w(drv.qw), .in_quat_x(drv.qx), .in_quat_y(drv.qy), .in_quat_z(drv.qz),
    .in_pos_in_x(drv.px), .in_pos_in_y(drv.py), .in_pos_in_z(drv.pz),
    .in_vel_in_x(drv.vx), .in_vel_in_y(drv.vy), .in_vel_in_z(drv.vz),
    .out_valid(out_valid),
    .out_pos_out_x(got.px), .out_pos_out_y(got.py), .out_pos_out_z(got.pz),
    .out_roll_angle(got.roll), .out_pitch_angle(got.pitch), .out_yaw_angle(got.yaw),
    .out_yaw_centideg(got.cd),
    .out_vel_out_x(got.vx), .out_vel_out_y(got.vy), .out_vel_out_z(got.vz)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n && out_valid) board.check_result(got);
    if (cycles > CYCLE_LIMIT) begin
      $display("pose_frame_to_euler_yaw_tb failed");
      $finish;
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    psel <= 1; penable <= 0; pwrite <= 1;
    paddr <= {idx, 2'b00}; pwdata <= value;
    @(negedge clk);
    penable <= 1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_MOUNT: board.mount = value[1:0];
      REG_OFF_E: board.offset[0] = longint'(signed'(value));
      REG_OFF_N: board.offset[1] = longint'(signed'(value));
      default:   board.offset[2] = longint'(signed'(value));
    endcase
    @(negedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    @(negedge clk);
  endtask

  // Holds start for one transaction; the caller decides whether to drop it.
  task automatic send_sample(pose_sample_t s);
    drv <= s;
    start <= 1;
    do @(posedge clk); while (busy);
    board.note_sample(s);
    @(negedge clk);
  endtask

  task automatic idle_cycles(int n);
    start <= 0;
    repeat (n) @(negedge clk);
  endtask

  task automatic drain();
    start <= 0;
    while (board.pending.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  function automatic logic [31:0] any_word(int kind);
    case (kind)
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom_range(0, 1) ? $urandom_range(0, 32'h7ffff)
                                     : -$urandom_range(0, 32'h7ffff);
      default: return $urandom;
    endcase
  endfunction

  // Mostly quaternions with components in [-16384, 16383], with raw random words mixed in.
  function automatic pose_sample_t random_sample();
    pose_sample_t s;
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 7) begin
      s.qw = 16'($urandom_range(0, 32767) - 16384);
      s.qx = 16'($urandom_range(0, 32767) - 16384);
      s.qy = 16'($urandom_range(0, 32767) - 16384);
      s.qz = 16'($urandom_range(0, 32767) - 16384);
      if (sel == 6) begin
        s.qx = '0;
        s.qz = '0;
        s.qw = $urandom_range(0, 1) ? 16'sd23170 : -16'sd23170;
        s.qy = $urandom_range(0, 1) ? 16'sd23170 : -16'sd23170;
      end
    end else begin
      s.qw = 16'($urandom); s.qx = 16'($urandom);
      s.qy = 16'($urandom); s.qz = 16'($urandom);
    end
    s.px = any_word($urandom_range(0, 6)); s.py = any_word($urandom_range(0, 6));
    s.pz = any_word($urandom_range(0, 6)); s.vx = any_word($urandom_range(0, 6));
    s.vy = any_word($urandom_range(0, 6)); s.vz = any_word($urandom_range(0, 6));
    return s;
  endfunction

  task automatic directed_set();
    pose_sample_t s;
    s = '{default: '0};
    s.qw = 16'sd32767;
    send_sample(s);
    s = '{qw: 16'sh8000, qx: 16'sh8000, qy: 16'sh8000, qz: 16'sh8000,
          px: 32'sh80000000, py: 32'sh80000000, pz: 32'sh80000000,
          vx: 32'sh80000000, vy: 32'sh80000000, vz: 32'sh80000000};
    send_sample(s);
    s = '{qw: 16'sh7fff, qx: 16'sh7fff, qy: 16'sh7fff, qz: 16'sh7fff,
          px: 32'sh7fffffff, py: 32'sh7fffffff, pz: 32'sh7fffffff,
          vx: 32'sh7fffffff, vy: 32'sh7fffffff, vz: 32'sh7fffffff};
    send_sample(s);
    // All-zero quaternion gives the identity matrix, as the diagonal terms start from one.
    s = '{default: '0};
    send_sample(s);
    // Pitch of plus and minus ninety degrees reach the singular branch under MODE_DOWN.
    s = '{default: '0}; s.qw = 16'sd23170; s.qy = 16'sd23170;
    send_sample(s);
    s.qy = -16'sd23170;
    send_sample(s);
    s = '{default: '0}; s.qx = 16'sd32767;
    send_sample(s);
    s = '{default: '0}; s.qz = 16'sd32767;
    send_sample(s);
    s = '{default: '0}; s.qy = 16'sd32767;
    send_sample(s);
    idle_cycles(1);
  endtask

  initial begin
    int sent, burst;
    logic [31:0] offsets [4][3];
    board = new();
    board.clear_config();
    repeat (7) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);
    offsets = '{'{0, 0, 0}, '{32'h7fffffff, 32'h80000000, 32'h7fffffff},
                '{32'h80000000, 32'h7fffffff, 32'h80000000},
                '{32'h00018000, 32'hfffe4000, 32'h00005000}};
    directed_set();
    drain();
    sent = 0;
    for (int phase = 0; phase < 8; phase++) begin
      write_reg(REG_MOUNT, (phase < 4) ? phase : $urandom_range(0, 3));
      write_reg(REG_OFF_E, (phase < 4) ? offsets[phase][0] : any_word($urandom_range(2, 3)));
      write_reg(REG_OFF_N, (phase < 4) ? offsets[phase][1] : any_word($urandom_range(2, 3)));
      write_reg(REG_OFF_U, (phase < 4) ? offsets[phase][2] : any_word($urandom_range(2, 3)));
      if (phase == 1) directed_set();
      while (sent < (phase + 1) * 64) begin
        burst = $urandom_range(1, 20);
        for (int i = 0; i < burst; i++) begin
          send_sample(random_sample());
          sent++;
        end
        if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 6));
      end
      drain();
    end
    if (board.errors == 0)
      $display("pose_frame_to_euler_yaw_tb passed");
    else
      $display("pose_frame_to_euler_yaw_tb failed");
    $finish;
  end
endmodule
